>>> hw/rtl/ihss_pkg.sv
// Shared types and result codes for the image header size sniffer.
`default_nettype none

package ihss_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] FMT_GIF  = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  fmt;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ihss_front.sv
// Byte parser: recognizes the file format and produces one result per file.
`default_nettype none

module ihss_front
  import ihss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             push,
  output result_t          push_data
);

  typedef enum logic [3:0] {
    PH_HEAD  = 4'b0001,
    PH_JSKIP = 4'b0010,
    PH_JHDR  = 4'b0100,
    PH_JSOF  = 4'b1000
  } phase_t;

  localparam logic [7:0] JPEG_SOI_HI = 8'hFF;
  localparam logic [7:0] JPEG_SOI_LO = 8'hD8;
  localparam logic [7:0] GIF_VER_7   = 8'h37;
  localparam logic [7:0] GIF_VER_9   = 8'h39;

  function automatic logic [7:0] gif_sig(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h47;
      3'd1:    v = 8'h49;
      3'd2:    v = 8'h46;
      3'd3:    v = 8'h38;
      3'd4:    v = 8'h37;
      default: v = 8'h61;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] png_sig(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] ihdr_tag(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h49;
      2'd1:    v = 8'h48;
      2'd2:    v = 8'h44;
      default: v = 8'h52;
    endcase
    return v;
  endfunction

  // SOFn: FFC0..FFCF except DHT (C4), JPG (C8) and DAC (CC)
  function automatic logic is_sof(input logic [15:0] m);
    return (m[15:4] == 12'hFFC) && (m[3:0] != 4'h4) && (m[3:0] != 4'h8) &&
           (m[3:0] != 4'hC);
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [4:0]  off_r, off_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [15:0] mk_r, mk_nxt;
  logic [15:0] sk_r, sk_nxt;
  logic [31:0] wh_r, wh_nxt;
  logic        done_r, done_nxt;
  logic        ihdr_bad_r, ihdr_bad_nxt;

  logic        emit;
  result_t     res;
  logic        stop;
  logic        seg_go;
  logic        gif_ok;
  logic [15:0] seg_len;
  logic [1:0]  hdr_off;

  assign seg_len = {sk_r[7:0], data_byte};
  assign hdr_off = off_r[1:0];

  always_comb begin
    phase_nxt    = phase_r;
    off_nxt      = off_r;
    cand_nxt     = cand_r;
    fs_nxt       = fs_r;
    mk_nxt       = mk_r;
    sk_nxt       = sk_r;
    wh_nxt       = wh_r;
    done_nxt     = done_r;
    ihdr_bad_nxt = ihdr_bad_r;
    emit         = 1'b0;
    res          = '{status: ST_OK, fmt: FMT_GIF, image_width: 32'd0, image_height: 32'd0};
    stop         = 1'b0;
    seg_go       = 1'b0;
    gif_ok       = 1'b0;

    if (accept && !done_r) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (cand_r[0]) begin
            if (off_r < 5'd6) begin
              if (off_r == 5'd4) begin
                gif_ok = (data_byte == GIF_VER_7) || (data_byte == GIF_VER_9);
              end else begin
                gif_ok = (data_byte == gif_sig(off_r[2:0]));
              end
              if (!gif_ok) cand_nxt[0] = 1'b0;
            end else if (off_r == 5'd6) begin
              wh_nxt = {24'd0, data_byte};
            end else if (off_r == 5'd7) begin
              wh_nxt = wh_r | {16'd0, data_byte, 8'd0};
            end else if (off_r == 5'd8) begin
              fs_nxt = {24'd0, data_byte};
            end else if (off_r == 5'd9) begin
              fs_nxt = fs_r | {16'd0, data_byte, 8'd0};
            end else if (off_r == 5'd12) begin
              emit = 1'b1;
              stop = 1'b1;
              res  = '{status: ST_OK, fmt: FMT_GIF, image_width: wh_r, image_height: fs_r};
            end
          end
          if (cand_r[1]) begin
            if (off_r < 5'd8) begin
              if (data_byte != png_sig(off_r[2:0])) cand_nxt[1] = 1'b0;
            end else if (off_r >= 5'd12 && off_r < 5'd16) begin
              if (data_byte != ihdr_tag(off_r[1:0])) ihdr_bad_nxt = 1'b1;
            end else if (off_r >= 5'd16 && off_r < 5'd20) begin
              wh_nxt = {wh_r[23:0], data_byte};
            end else if (off_r >= 5'd20 && off_r < 5'd24) begin
              fs_nxt = {fs_r[23:0], data_byte};
            end else if (off_r == 5'd27) begin
              emit = 1'b1;
              stop = 1'b1;
              if (ihdr_bad_r) begin
                res = '{status: ST_INVALID, fmt: FMT_PNG, image_width: 32'd0,
                        image_height: 32'd0};
              end else begin
                res = '{status: ST_OK, fmt: FMT_PNG, image_width: wh_r, image_height: fs_r};
              end
            end
          end
          if (cand_r[2]) begin
            if (off_r == 5'd0) begin
              if (data_byte != JPEG_SOI_HI) cand_nxt[2] = 1'b0;
            end else if (off_r == 5'd1) begin
              if (data_byte != JPEG_SOI_LO) cand_nxt[2] = 1'b0;
            end else if (off_r == 5'd2) begin
              mk_nxt = {8'd0, data_byte};
            end else if (off_r == 5'd3) begin
              mk_nxt = {mk_r[7:0], data_byte};
            end else if (off_r == 5'd4) begin
              sk_nxt = {8'd0, data_byte};
            end else if (off_r == 5'd5) begin
              seg_go = 1'b1;
              stop   = 1'b1;
            end
          end
          if (!stop) begin
            if (cand_nxt == 3'd0) begin
              emit = 1'b1;
              res  = '{status: ST_UNKNOWN, fmt: FMT_GIF, image_width: 32'd0,
                       image_height: 32'd0};
            end else begin
              off_nxt = off_r + 5'd1;
            end
          end
        end
        PH_JSKIP: begin
          sk_nxt = sk_r - 16'd1;
          if (sk_r == 16'd1) begin
            phase_nxt = PH_JHDR;
            off_nxt   = 5'd0;
          end
        end
        PH_JHDR: begin
          case (hdr_off)
            2'd0:    mk_nxt = {8'd0, data_byte};
            2'd1:    mk_nxt = {mk_r[7:0], data_byte};
            2'd2:    sk_nxt = {8'd0, data_byte};
            default: seg_go = 1'b1;
          endcase
          if (hdr_off != 2'd3) off_nxt = {3'd0, hdr_off} + 5'd1;
        end
        PH_JSOF: begin
          if (off_r == 5'd1) begin
            fs_nxt = {24'd0, data_byte};
          end else if (off_r == 5'd2) begin
            fs_nxt = {16'd0, fs_r[7:0], data_byte};
          end else if (off_r == 5'd3) begin
            wh_nxt = {24'd0, data_byte};
          end else if (off_r == 5'd4) begin
            wh_nxt = {16'd0, wh_r[7:0], data_byte};
          end else if (off_r >= 5'd5) begin
            emit = 1'b1;
            res  = '{status: ST_OK, fmt: FMT_JPEG, image_width: wh_r, image_height: fs_r};
          end
          off_nxt = off_r + 5'd1;
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase

      // complete segment header: marker in mk_r, length just assembled
      if (seg_go) begin
        sk_nxt = seg_len;
        if (seg_len < 16'd2) begin
          emit = 1'b1;
          res  = '{status: ST_INVALID, fmt: FMT_JPEG, image_width: 32'd0,
                   image_height: 32'd0};
        end else begin
          off_nxt = 5'd0;
          if (is_sof(mk_r)) begin
            phase_nxt = PH_JSOF;
          end else if (seg_len == 16'd2) begin
            phase_nxt = PH_JHDR;
          end else begin
            sk_nxt    = seg_len - 16'd2;
            phase_nxt = PH_JSKIP;
          end
        end
      end

      if (emit) done_nxt = 1'b1;
    end

    if (accept && last_byte) begin
      if (!done_r && !emit) begin
        emit = 1'b1;
        if (phase_nxt == PH_HEAD) begin
          res = '{status: ST_UNKNOWN, fmt: FMT_GIF, image_width: 32'd0, image_height: 32'd0};
        end else begin
          res = '{status: ST_INVALID, fmt: FMT_JPEG, image_width: 32'd0,
                  image_height: 32'd0};
        end
      end
      // end of file: back to start for the next one
      phase_nxt    = PH_HEAD;
      off_nxt      = 5'd0;
      cand_nxt     = 3'b111;
      fs_nxt       = 32'd0;
      mk_nxt       = 16'd0;
      sk_nxt       = 16'd0;
      wh_nxt       = 32'd0;
      done_nxt     = 1'b0;
      ihdr_bad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD;
      off_r      <= 5'd0;
      cand_r     <= 3'b111;
      fs_r       <= 32'd0;
      mk_r       <= 16'd0;
      sk_r       <= 16'd0;
      wh_r       <= 32'd0;
      done_r     <= 1'b0;
      ihdr_bad_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      off_r      <= off_nxt;
      cand_r     <= cand_nxt;
      fs_r       <= fs_nxt;
      mk_r       <= mk_nxt;
      sk_r       <= sk_nxt;
      wh_r       <= wh_nxt;
      done_r     <= done_nxt;
      ihdr_bad_r <= ihdr_bad_nxt;
    end
  end

  assign push      = emit;
  assign push_data = res;

endmodule

`default_nettype wire

>>> hw/rtl/ihss_queue.sv
// Small result queue between the parser and the output stage.
`default_nettype none

module ihss_queue
  import ihss_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output result_t      pop_data,
  output logic         full,
  output logic         not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  result_t       slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assign pop_data  = slot_r[rd_ptr_r];
  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);

endmodule

`default_nettype wire

>>> hw/rtl/ihss_back.sv
// Output register stage: drains the result queue onto the result channel.
`default_nettype none

module ihss_back
  import ihss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_not_empty,
  input  wire result_t q_data,
  output logic         q_pop,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // load when the register is empty or its transaction completes this cycle
  assign q_pop = q_not_empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_data;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/image_header_size_sniffer_top.sv
// Top level of the image header size sniffer: parser, result queue, output stage.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   in_     | input     | in_valid/in_stall   | data_byte[7:0], last_byte
//   out_    | output    | out_valid/out_stall | status[1:0], format[1:0], image_width[31:0],
//           |           |                    | image_height[31:0]
//
// One byte is taken per cycle when not stalled; the parser updates its counters and shift
// registers in the cycle a byte is accepted and pushes at most one result per file.
// A result is written into the queue, then registered in the output stage onto out_valid.
// in_stall rises only while the result queue is full (QUEUE_DEPTH entries).
// rst_n is synchronous, active low, and returns the parser to the start of a file.
`default_nettype none

module image_header_size_sniffer_top
  import ihss_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [1:0]       out_format,
  output logic [31:0]      out_image_width,
  output logic [31:0]      out_image_height
);

  logic    accept;
  logic    push;
  result_t push_data;
  logic    pop;
  result_t pop_data;
  logic    q_full;
  logic    q_not_empty;
  result_t out_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  ihss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (push),
    .push_data (push_data)
  );

  ihss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  ihss_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  assign out_status       = out_data.status;
  assign out_format       = out_data.fmt;
  assign out_image_width  = out_data.image_width;
  assign out_image_height = out_data.image_height;

endmodule

`default_nettype wire
